// File: src/pcxrle_pkg.sv
`default_nettype none

package pcxrle_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int TOTAL_W = 25;
    localparam int COUNT_W = 24;
    localparam int RUN_W   = 6;
    localparam int COLOR_W = 24;

    localparam logic [7:0]         RUN_MARK  = 8'd192;
    localparam logic [7:0]         RUN_MASK  = 8'd63;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 25'h1000000;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_IMAGE   = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit_start;
        logic last_pix;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/pcxrle_ram.sv
`default_nettype none

module pcxrle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/pcxrle_ctrl.sv
`default_nettype none

module pcxrle_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire pcxrle_pkg::dp_stat_t   stat_i,
    output pcxrle_pkg::ctrl_cmd_t       cmd_o
);

    import pcxrle_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_o.take && stat_i.emit_start) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd_o.step && stat_i.last_pix) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EMIT: m_tvalid = 1'b1;
            default: s_tready = 1'b0;
        endcase
        cmd_o.take = s_tvalid & s_tready;
        cmd_o.step = m_tvalid & m_tready;
    end

endmodule

`default_nettype wire

// File: src/pcxrle_dp.sv
`default_nettype none

module pcxrle_dp #(
    parameter int PALETTE_DEPTH = pcxrle_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire pcxrle_pkg::ctrl_cmd_t          cmd_i,
    output pcxrle_pkg::dp_stat_t                stat_o,
    input  wire logic                           s_tuser,
    input  wire logic [39:0]                    s_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [pcxrle_pkg::TOTAL_W-1:0] cfg_data,
    output logic      [23:0]                    m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    import pcxrle_pkg::*;

    localparam int         AW        = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] code_byte;

    logic               is_image;
    logic               is_mark;
    logic               idx_ok;
    logic               code_ok;
    logic               wr_en;
    logic               rd_en;
    logic               last_img;
    logic [COLOR_W-1:0] ram_q;
    logic [COLOR_W-1:0] color;
    logic [TOTAL_W-1:0] total_cfg;

    logic               run_pending_reg, run_pending_next;
    logic [RUN_W-1:0]   run_len_reg,     run_len_next;
    logic [RUN_W-1:0]   remain_reg,      remain_next;
    logic [COUNT_W-1:0] pix_done_reg,    pix_done_next;
    logic [TOTAL_W-1:0] total_reg,       total_next;
    logic               rd_ok_reg,       rd_ok_next;

    assign entry_index = s_tdata[7:0];
    assign entry_red   = s_tdata[15:8];
    assign entry_green = s_tdata[23:16];
    assign entry_blue  = s_tdata[31:24];
    assign code_byte   = s_tdata[39:32];

    assign is_image = (s_tuser == CMD_IMAGE);
    assign is_mark  = ((code_byte & RUN_MARK) == RUN_MARK);
    assign idx_ok   = ({1'b0, entry_index} < DEPTH_LIM);
    assign code_ok  = ({1'b0, code_byte} < DEPTH_LIM);
    assign wr_en    = cmd_i.take & !is_image & idx_ok;
    assign rd_en    = cmd_i.take & is_image;

    pcxrle_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (entry_index[AW-1:0]),
        .wr_data ({entry_red, entry_green, entry_blue}),
        .rd_en   (rd_en),
        .rd_addr (code_byte[AW-1:0]),
        .rd_data (ram_q)
    );

    // saturate the configured total into 1 .. 2^24
    always_comb begin
        priority if (cfg_data == '0) begin
            total_cfg = TOTAL_W'(1);
        end else if (cfg_data > TOTAL_MAX) begin
            total_cfg = TOTAL_MAX;
        end else begin
            total_cfg = cfg_data;
        end
    end

    assign last_img = (({1'b0, pix_done_reg} + TOTAL_W'(1)) >= total_reg);

    assign stat_o.emit_start = is_image &
                               (run_pending_reg ? (run_len_reg != '0) : !is_mark);
    assign stat_o.last_pix   = last_img | (remain_reg == RUN_W'(1));

    always_comb begin
        run_pending_next = run_pending_reg;
        run_len_next     = run_len_reg;
        remain_next      = remain_reg;
        pix_done_next    = pix_done_reg;
        rd_ok_next       = rd_ok_reg;
        total_next       = cfg_we ? total_cfg : total_reg;

        if (cmd_i.take && is_image) begin
            rd_ok_next = code_ok;
            priority if (run_pending_reg) begin
                run_pending_next = 1'b0;
                run_len_next     = '0;
                remain_next      = run_len_reg;
            end else if (is_mark) begin
                run_pending_next = 1'b1;
                run_len_next     = RUN_W'(code_byte & RUN_MASK);
            end else begin
                remain_next = RUN_W'(1);
            end
        end

        if (cmd_i.step) begin
            remain_next   = remain_reg - RUN_W'(1);
            pix_done_next = last_img ? '0 : pix_done_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_pending_reg <= 1'b0;
            run_len_reg     <= '0;
            remain_reg      <= '0;
            pix_done_reg    <= '0;
            total_reg       <= TOTAL_W'(1);
            rd_ok_reg       <= 1'b0;
        end else begin
            run_pending_reg <= run_pending_next;
            run_len_reg     <= run_len_next;
            remain_reg      <= remain_next;
            pix_done_reg    <= pix_done_next;
            total_reg       <= total_next;
            rd_ok_reg       <= rd_ok_next;
        end
    end

    assign color   = rd_ok_reg ? ram_q : '0;
    assign m_tdata = {color[7:0], color[15:8], color[23:16]};
    assign m_tuser = stat_o.last_pix;
    assign m_tlast = last_img;

endmodule

`default_nettype wire

// File: src/pcx_rle_palette_decoder_top.sv
// PCX 8-bit run-length decoder with palette expansion. Load the palette with
// tuser 0 items, set cfg_data to the pixel count of one image (0 acts as 1,
// above 2^24 as 2^24), then stream image bytes with tuser 1; each decoded pixel
// leaves as one RGB item, tlast marking the last pixel of the image and tuser
// the last pixel caused by one input byte (a run past the image end is clipped
// there). A palette write or a run marker emits no pixel and leaves the input
// ready; a literal byte gives one pixel, a repeated byte run-length pixels,
// read via the palette RAM's registered read and output one pixel per cycle
// while m_tready is high; the input is held off while pixels are emitted.
`default_nettype none

module pcx_rle_palette_decoder_top #(
    parameter int PALETTE_DEPTH = pcxrle_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_index, entry_red, entry_green, entry_blue, code_byte
    input  wire logic [39:0]                    s_tdata,
    // cmd
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // pixel_red, pixel_green, pixel_blue
    output logic      [23:0]                    m_tdata,
    // last_of_run
    output logic                                m_tuser,
    // last_of_image
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pcxrle_pkg::TOTAL_W-1:0] cfg_data
);

    import pcxrle_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    pcxrle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    pcxrle_dp #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_i    (cmd),
        .stat_o   (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: src/pcxrle_chk.sv
`default_nettype none

module pcxrle_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while pixels pending");

    a_img_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("image end without run end");

    a_run_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=> !m_tvalid && s_tready)
        else $error("output continues past run end");

endmodule

bind pcx_rle_palette_decoder_top pcxrle_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pcxrle_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 180;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_end;
        logic       image_end;
    } pixel_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [23:0]        m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TOTAL_W-1:0] cfg_data  = '0;

    pcx_rle_palette_decoder_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // decoder shadow state
    logic [23:0]        palette_rgb [256];
    logic [TOTAL_W-1:0] pixel_total_reg = 25'd1;
    logic               run_armed       = 1'b0;
    logic [5:0]         run_count       = '0;
    logic [23:0]        pixels_seen     = '0;

    pixel_t expected_pixels [$];
    int     errors = 0;
    bit     idling = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= idling ? ($urandom_range(99) >= 6) : 1'b1;
    end

    function automatic logic [TOTAL_W-1:0] image_size();
        if (pixel_total_reg == '0) return 25'd1;
        if (pixel_total_reg > TOTAL_MAX) return TOTAL_MAX;
        return pixel_total_reg;
    endfunction

    task automatic decode_item(input logic cmd, input logic [39:0] data);
        logic [7:0]         code;
        logic [6:0]         repeats;
        logic [23:0]        rgb;
        logic [TOTAL_W-1:0] size;
        logic               done;
        pixel_t             px;
        if (cmd == CMD_PALETTE) begin
            palette_rgb[data[7:0]] = {data[15:8], data[23:16], data[31:24]};
            return;
        end
        code = data[39:32];
        if (run_armed) begin
            repeats   = {1'b0, run_count};
            run_armed = 1'b0;
            run_count = '0;
        end else if ((code & RUN_MARK) == RUN_MARK) begin
            run_armed = 1'b1;
            run_count = 6'(code & RUN_MASK);
            return;
        end else begin
            repeats = 7'd1;
        end
        rgb  = palette_rgb[code];
        size = image_size();
        done = 1'b0;
        for (int k = 0; k < repeats && !done; k++) begin
            px.red       = rgb[23:16];
            px.green     = rgb[15:8];
            px.blue      = rgb[7:0];
            px.image_end = ({1'b0, pixels_seen} + 25'd1) >= size;
            px.run_end   = px.image_end || (k + 1 == repeats);
            expected_pixels.push_back(px);
            if (px.image_end) begin
                pixels_seen = '0;
                done        = 1'b1;
            end else begin
                pixels_seen = pixels_seen + 24'd1;
            end
        end
    endtask

    always @(posedge aclk) begin : pixel_check
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel %h run_end %b image_end %b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[7:0] !== want.red) begin
                    $error("pixel_red expected %0h got %0h", want.red, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("pixel_green expected %0h got %0h", want.green, m_tdata[15:8]);
                    errors++;
                end
                if (m_tdata[23:16] !== want.blue) begin
                    $error("pixel_blue expected %0h got %0h", want.blue, m_tdata[23:16]);
                    errors++;
                end
                if (m_tuser !== want.run_end) begin
                    $error("last_of_run expected %0b got %0b", want.run_end, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.image_end) begin
                    $error("last_of_image expected %0b got %0b", want.image_end, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no item moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [39:0] data);
        int gap;
        if (idling && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        decode_item(cmd, data);
    endtask

    task automatic send_code(input logic [7:0] code);
        send_item(CMD_IMAGE, {code, 32'($urandom())});
    endtask

    task automatic send_run(input logic [5:0] length, input logic [7:0] code);
        send_code(RUN_MARK | {2'b00, length});
        send_code(code);
    endtask

    task automatic send_entry(input logic [7:0] index, input logic [23:0] rgb);
        logic [7:0] filler;
        filler = 8'($urandom_range(255));
        send_item(CMD_PALETTE, {filler, rgb[7:0], rgb[15:8], rgb[23:16], index});
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_pixel_total(input logic [TOTAL_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pixel_total_reg = value;
    endtask

    task automatic load_palette();
        send_entry(8'd0, 24'h000000);
        for (int i = 1; i < 255; i++) send_entry(8'(i), 24'($urandom()));
        send_entry(8'd255, 24'hFFFFFF);
    endtask

    task automatic test_default_total();
        send_code(8'h00);
        send_run(6'd5, 8'h10);
    endtask

    task automatic test_literals();
        write_pixel_total(25'd1000);
        send_code(8'h00);
        send_code(8'hBF);
        send_code(8'h80);
    endtask

    task automatic test_runs();
        send_run(6'd63, 8'hFF);
        send_run(6'd1, 8'h05);
        send_run(6'd0, 8'h22);
        send_run(6'd2, RUN_MARK);
    endtask

    task automatic test_palette_during_run();
        send_code(RUN_MARK | 8'd4);
        send_entry(8'd7, 24'h5AA5C3);
        send_code(8'd7);
    endtask

    task automatic test_run_clipping();
        write_pixel_total(25'd1);
        send_code(8'h01);
        write_pixel_total(25'd10);
        send_run(6'd20, 8'h33);
        send_run(6'd5, 8'h44);
    endtask

    task automatic test_total_lowered();
        write_pixel_total(25'd60);
        send_run(6'd40, 8'h12);
        write_pixel_total(25'd10);
        send_code(8'h02);
        send_code(8'h03);
    endtask

    task automatic test_total_range();
        write_pixel_total(25'd0);
        send_run(6'd4, 8'h11);
        write_pixel_total(25'h1FFFFFF);
        send_run(6'd9, 8'h66);
        write_pixel_total(TOTAL_MAX);
        send_code(8'h77);
    endtask

    task automatic test_random_stream();
        int sent;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idling = !(sent >= 60 && sent < 120);
            pick   = $urandom_range(99);
            if (pick < 40) begin
                send_code(8'($urandom_range(191)));
                sent += 1;
            end else if (pick < 75) begin
                if ($urandom_range(9) == 0)
                    send_run(6'($urandom_range(63)), 8'($urandom_range(255)));
                else
                    send_run(6'($urandom_range(1, 8)), 8'($urandom_range(255)));
                sent += 2;
            end else if (pick < 85) begin
                send_entry(8'($urandom_range(255)), 24'($urandom()));
                sent += 1;
            end else if (pick < 90) begin
                send_run(6'd0, 8'($urandom_range(255)));
                sent += 2;
            end else if (pick < 93) begin
                // hold the sender until the decoder is empty
                send_code(RUN_MARK | 8'($urandom_range(63)));
                wait_drained();
                send_code(8'($urandom_range(255)));
                sent += 2;
            end else begin
                case ($urandom_range(7))
                    0:       write_pixel_total(25'd0);
                    1:       write_pixel_total(25'd1);
                    2:       write_pixel_total(25'd2);
                    3, 4:    write_pixel_total(25'($urandom_range(3, 40)));
                    5:       write_pixel_total(25'($urandom_range(41, 400)));
                    6:       write_pixel_total(TOTAL_MAX);
                    default: write_pixel_total(25'h1FFFFFF);
                endcase
            end
        end
        idling = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_palette();
        test_default_total();
        test_literals();
        test_runs();
        test_palette_during_run();
        test_run_clipping();
        test_total_lowered();
        test_total_range();
        test_random_stream();
        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
